### sv/uuenc_pkg.sv
// ----------------------------------------------------------------------------
// uuenc_pkg
// Shared types, constants and the 6-bit character map of the uuencode
// line encoder.
// ----------------------------------------------------------------------------
package uuenc_pkg;

  localparam int LINE_BYTES_DEF = 45;
  localparam int CNT_W          = 6;
  localparam int MEM_AW         = 7;   // two line banks at the largest line length

  localparam logic [7:0] CHAR_BQ  = 8'h60;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_OFS = 8'h20;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic        en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic wr_bank;
    job_t head;
  } q_stat_t;

  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] r;
    if (v == 6'd0) begin
      r = CHAR_BQ;
    end else begin
      r = {2'b00, v} + CHAR_OFS;
    end
    return r;
  endfunction

endpackage

### sv/uuenc_line_mem.sv
// ----------------------------------------------------------------------------
// uuenc_line_mem
// Two-bank line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uuenc_line_mem #(
  parameter int LINE_BYTES = uuenc_pkg::LINE_BYTES_DEF
) (
  input  logic                          clk,
  input  uuenc_pkg::mem_wr_t            wr,
  input  logic                          rd_en,
  input  logic [uuenc_pkg::MEM_AW-1:0]  rd_addr,
  output logic [7:0]                    rd_data
);

  localparam int DEPTH = 2 * LINE_BYTES;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/uuenc_front.sv
// ----------------------------------------------------------------------------
// uuenc_front
// Takes payload bytes, stores them into the current line bank and posts a
// line job when the line is full or the last byte arrives.
// ----------------------------------------------------------------------------
module uuenc_front #(
  parameter int LINE_BYTES = uuenc_pkg::LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  input  uuenc_pkg::q_stat_t  qs,
  output uuenc_pkg::mem_wr_t  wr,
  output logic                job_push,
  output uuenc_pkg::job_t     job
);

  localparam logic [uuenc_pkg::MEM_AW-1:0] BANK_BASE =
    uuenc_pkg::MEM_AW'(LINE_BYTES);
  localparam logic [uuenc_pkg::CNT_W-1:0] LAST_IDX =
    uuenc_pkg::CNT_W'(LINE_BYTES - 1);

  logic [uuenc_pkg::CNT_W-1:0] count;
  logic [uuenc_pkg::CNT_W-1:0] count_next;
  logic                        accept;
  logic                        line_done;

  assign full      = qs.full;
  assign accept    = push && !qs.full;
  assign line_done = final_byte || (count == LAST_IDX);
  assign count_next = count + uuenc_pkg::CNT_W'(1);

  assign wr.en   = accept;
  assign wr.addr = (qs.wr_bank ? BANK_BASE : '0) + uuenc_pkg::MEM_AW'(count);
  assign wr.data = data_byte;

  assign job_push = accept && line_done;
  assign job.bank = qs.wr_bank;
  assign job.cnt  = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= line_done ? '0 : count_next;
    end
  end

endmodule

### sv/uuenc_job_q.sv
// ----------------------------------------------------------------------------
// uuenc_job_q
// Two-entry queue of finished lines; entry slot doubles as the line bank.
// ----------------------------------------------------------------------------
module uuenc_job_q (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_push,
  input  uuenc_pkg::job_t    job,
  input  logic               job_pop,
  output uuenc_pkg::q_stat_t qs
);

  logic [uuenc_pkg::CNT_W-1:0] cnt_q [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  level;

  assign qs.full      = (level == 2'd2);
  assign qs.empty     = (level == 2'd0);
  assign qs.wr_bank   = wr_ptr;
  assign qs.head.bank = rd_ptr;
  assign qs.head.cnt  = cnt_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (job_push) begin
      cnt_q[wr_ptr] <= job.cnt;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (job_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= !rd_ptr;
      end
      level <= level + {1'b0, job_push} - {1'b0, job_pop};
    end
  end

endmodule

### sv/uuenc_back.sv
// ----------------------------------------------------------------------------
// uuenc_back
// Emits one line per job: length char, optional dot, four chars per
// three-byte group fetched from the line buffer, CR and LF.
// ----------------------------------------------------------------------------
module uuenc_back #(
  parameter int LINE_BYTES = uuenc_pkg::LINE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  uuenc_pkg::q_stat_t            qs,
  output logic                          job_pop,
  output logic                          rd_en,
  output logic [uuenc_pkg::MEM_AW-1:0]  rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_char,
  output logic                          run_end
);

  localparam int CW = uuenc_pkg::CNT_W;
  localparam logic [uuenc_pkg::MEM_AW-1:0] BANK_BASE =
    uuenc_pkg::MEM_AW'(LINE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_DOT, S_RD, S_CH, S_CR, S_LF
  } state_t;

  state_t      state;
  logic        out_valid;
  logic        bank;
  logic [CW-1:0] cnt;
  logic [CW-1:0] g;
  logic [1:0]  k;
  logic [1:0]  j;
  logic [7:0]  b0, b1, b2;

  logic        can_emit;
  logic        emit;
  logic [CW:0] rd_idx;
  logic [CW:0] prev_idx;
  logic        prev_hit;
  logic [7:0]  cap_byte;
  logic [CW:0] g_next;
  logic [7:0]  lenc;
  logic [7:0]  grp_char;

  assign empty    = !out_valid;
  assign can_emit = !out_valid || pop;
  assign emit     = can_emit && (state == S_LEN || state == S_DOT || state == S_CH ||
                                 state == S_CR || state == S_LF);
  assign job_pop  = (state == S_LF) && can_emit;

  assign rd_idx   = {1'b0, g} + {{(CW-1){1'b0}}, k};
  assign prev_idx = rd_idx - (CW+1)'(1);
  assign prev_hit = prev_idx < {1'b0, cnt};
  assign cap_byte = prev_hit ? rd_data : 8'd0;
  assign rd_en    = (state == S_RD) && (k != 2'd3) && (rd_idx < {1'b0, cnt});
  assign rd_addr  = (bank ? BANK_BASE : '0) + uuenc_pkg::MEM_AW'(rd_idx);
  assign g_next   = {1'b0, g} + (CW+1)'(3);
  assign lenc     = uuenc_pkg::enc6(cnt);

  always_comb begin
    unique case (j)
      2'd0:    grp_char = uuenc_pkg::enc6(b0[7:2]);
      2'd1:    grp_char = uuenc_pkg::enc6({b0[1:0], b1[7:4]});
      2'd2:    grp_char = uuenc_pkg::enc6({b1[3:0], b2[7:6]});
      default: grp_char = uuenc_pkg::enc6(b2[5:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            cnt   <= qs.head.cnt;
            bank  <= qs.head.bank;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (can_emit) begin
            out_char  <= lenc;
            run_end   <= 1'b0;
            g         <= '0;
            k         <= 2'd0;
            state     <= (lenc == uuenc_pkg::CHAR_DOT) ? S_DOT : S_RD;
          end
        end
        S_DOT: begin
          if (can_emit) begin
            out_char  <= uuenc_pkg::CHAR_DOT;
            run_end   <= 1'b0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          unique case (k)
            2'd1:    b0 <= cap_byte;
            2'd2:    b1 <= cap_byte;
            2'd3:    b2 <= cap_byte;
            default: ;
          endcase
          k <= k + 2'd1;
          if (k == 2'd3) begin
            j     <= 2'd0;
            state <= S_CH;
          end
        end
        S_CH: begin
          if (can_emit) begin
            out_char  <= grp_char;
            run_end   <= 1'b0;
            j         <= j + 2'd1;
            if (j == 2'd3) begin
              g     <= g_next[CW-1:0];
              k     <= 2'd0;
              state <= (g_next >= {1'b0, cnt}) ? S_CR : S_RD;
            end
          end
        end
        S_CR: begin
          if (can_emit) begin
            out_char  <= uuenc_pkg::CHAR_CR;
            run_end   <= 1'b0;
            state     <= S_LF;
          end
        end
        S_LF: begin
          if (can_emit) begin
            out_char  <= uuenc_pkg::CHAR_LF;
            run_end   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_run_end_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_end) |-> (out_char == uuenc_pkg::CHAR_LF))
    else $error("run_end on a character other than LF");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_CH || state == S_CR || state == S_LF) |-> (cnt != '0))
    else $error("line in progress with zero length");

  a_group_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_CH) |-> (g < cnt))
    else $error("group pointer past line length");

  a_pop_to_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == S_IDLE && out_valid && run_end))
    else $error("line job released without closing the line");

endmodule

### sv/uuencode_line_encoder.sv
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Binary bytes in, uuencoded text lines out, one character per item.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into one of two line banks until both banks
// hold finished lines; full then stays high until the output side releases a
// bank. The output side emits one character per cycle while pop keeps up, but
// pauses on each three-byte group to fetch its bytes (three reads through the
// single read port of the line buffer, whose read data is registered) before
// its four characters, and each line adds states for taking the job, length,
// optional dot, CR and LF. run_end is high on the LF closing each line. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module uuencode_line_encoder #(
  parameter int LINE_BYTES = uuenc_pkg::LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       run_end
);

  uuenc_pkg::q_stat_t               qs;
  uuenc_pkg::mem_wr_t               wr;
  uuenc_pkg::job_t                  job;
  logic                             job_push;
  logic                             job_pop;
  logic                             rd_en;
  logic [uuenc_pkg::MEM_AW-1:0]     rd_addr;
  logic [7:0]                       rd_data;

  uuenc_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .qs         (qs),
    .wr         (wr),
    .job_push   (job_push),
    .job        (job)
  );

  uuenc_job_q u_job_q (
    .clk      (clk),
    .rst      (rst),
    .job_push (job_push),
    .job      (job),
    .job_pop  (job_pop),
    .qs       (qs)
  );

  uuenc_line_mem #(.LINE_BYTES(LINE_BYTES)) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uuenc_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .qs       (qs),
    .job_pop  (job_pop),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .run_end  (run_end)
  );

endmodule
